@@ sv/acc_pkg.sv @@
// ---------------------------------------------------------------------------
// acc_pkg: shared types and codes of the A* OPEN/CLOSED engine
// Holds the OPEN list entry layout, the operation codes and the status codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package acc_pkg;

  // One OPEN list entry, 56 bits.
  typedef struct packed {
    logic [3:0]  heading;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [23:0] f;
    logic [15:0] handle;
  } entry_t;

  // Operation codes carried in in_tuser.
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;
  localparam logic [1:0] KIND_QUERY = 2'd3;

  // Status codes carried in out_tuser.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

endpackage

@@ sv/acc_open_ram.sv @@
// ---------------------------------------------------------------------------
// acc_open_ram: OPEN list storage
// Single write port, single read port, read data registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module acc_open_ram
  import acc_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/acc_closed_map.sv @@
// ---------------------------------------------------------------------------
// acc_closed_map: CLOSED bitmap
// One bit per vertex with a registered read. After reset a clearing pass
// walks every bit once while busy is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module acc_closed_map #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          set_en,
  input  logic [AW-1:0] set_addr,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_bit,
  output logic          busy
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic          mem [DEPTH];
  logic          rd_bit_r;
  logic          busy_r, busy_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  // Clearing pass sequencing.
  always_comb begin
    busy_nxt     = busy_r;
    clr_addr_nxt = clr_addr_r;
    if (busy_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == LAST) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      busy_r     <= busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Write port: zeros during the clearing pass, set bits afterwards.
  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_addr_r] <= 1'b0;
    end else if (set_en) begin
      mem[set_addr] <= 1'b1;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_bit_r <= mem[rd_addr];
    end
  end

  assign rd_bit = rd_bit_r;
  assign busy   = busy_r;

endmodule

@@ sv/astar_open_closed_engine.sv @@
// ---------------------------------------------------------------------------
// astar_open_closed_engine: A* OPEN list and CLOSED bitmap
// OPEN is a list sorted by f in a ring buffer memory; CLOSED is a bitmap
// memory. A sequencer runs one operation at a time against both.
//
//  channel | dir | beat contents
//  --------+-----+----------------------------------------------------------
//  in_     | in  | tuser: kind; tdata: handle, f, row, col, heading
//  out_    | out | tuser: status; tdata: handle, f, row, col, heading, flags
//
// A push walks back from the tail, moving each entry with larger f back by one,
// and then writes the new entry in the gap; a push to a full list stores nothing
// and returns full status. A pop takes the head entry and discards it while its
// vertex is closed, until it finds one that is not or the list is empty; close
// sets the vertex bit and query reads it. Each operation returns to idle before
// the next beat is taken. The OPEN memory read-modify-write loop paces push and pop.
// After reset no beat is accepted while the CLOSED clearing pass walks all
// GRID_ROWS*GRID_COLS*HEADINGS bits.
// A finished result waits in the output register; a stalled output holds the
// sequencer only when the next result is ready to be loaded.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module astar_open_closed_engine
  import acc_pkg::*;
#(
  parameter int GRID_ROWS  = 64,
  parameter int GRID_COLS  = 64,
  parameter int HEADINGS   = 16,
  parameter int OPEN_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // kind
  input  logic [55:0] in_tdata,   // node_handle, f_value, row, col, heading
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // status
  output logic [63:0] out_tdata   // out_handle, out_f, out_row, out_col,
                                  // out_heading, is_closed, open_empty, zeros
);

  localparam int LAW       = (OPEN_DEPTH > 1) ? $clog2(OPEN_DEPTH) : 1;
  localparam int CW        = $clog2(OPEN_DEPTH + 1);
  localparam int PLANE     = GRID_ROWS * GRID_COLS;
  localparam int MAP_DEPTH = HEADINGS * PLANE;
  localparam int MAW       = $clog2(MAP_DEPTH);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_PUSH_RD   = 4'd1;
  localparam logic [3:0] ST_PUSH_CMP  = 4'd2;
  localparam logic [3:0] ST_POP_RD    = 4'd3;
  localparam logic [3:0] ST_POP_MAP   = 4'd4;
  localparam logic [3:0] ST_POP_CHK   = 4'd5;
  localparam logic [3:0] ST_QUERY_RD  = 4'd6;
  localparam logic [3:0] ST_QUERY_CHK = 4'd7;
  localparam logic [3:0] ST_FINISH    = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [1:0]    kind_r, kind_nxt;
  entry_t        req_r, req_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [LAW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  entry_t        res_entry_r, res_entry_nxt;
  logic          res_closed_r, res_closed_nxt;
  logic          ingrid_r, ingrid_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_user_r, out_user_nxt;
  logic [63:0]   out_data_r, out_data_nxt;

  logic           ram_wr_en, ram_rd_en;
  logic [LAW-1:0] ram_wr_addr, ram_rd_addr;
  entry_t         ram_wr_data, ram_rd_data;
  logic           map_set_en, map_rd_en, map_rd_bit, map_busy;
  logic [MAW-1:0] map_set_addr, map_rd_addr;
  logic           req_in, pop_in;
  logic [MAW-1:0] req_idx, pop_idx;
  entry_t         in_entry;

  // Ring address of an offset from the list head.
  function automatic logic [LAW-1:0] ring_addr(input logic [LAW-1:0] head,
                                                input logic [CW-1:0]  off);
    logic [LAW+1:0] sum;
    sum = (LAW+2)'(head) + (LAW+2)'(off);
    if (sum >= (LAW+2)'(OPEN_DEPTH)) begin
      sum = sum - (LAW+2)'(OPEN_DEPTH);
    end
    return sum[LAW-1:0];
  endfunction

  // Bitmap index of a vertex.
  function automatic logic [MAW-1:0] vertex_idx(input entry_t e);
    logic [31:0] idx;
    idx = 32'(e.heading) * 32'(PLANE) + 32'(e.row) * 32'(GRID_COLS) + 32'(e.col);
    return idx[MAW-1:0];
  endfunction

  // Whether a vertex lies inside the grid.
  function automatic logic vertex_in(input entry_t e);
    return (32'(e.row) < 32'(GRID_ROWS)) && (32'(e.col) < 32'(GRID_COLS)) &&
           (32'(e.heading) < 32'(HEADINGS));
  endfunction

  assign in_entry = entry_t'(in_tdata);
  assign req_in   = vertex_in(req_r);
  assign req_idx  = vertex_idx(req_r);
  assign pop_in   = vertex_in(ram_rd_data);
  assign pop_idx  = vertex_idx(ram_rd_data);

  acc_open_ram #(
    .DEPTH (OPEN_DEPTH),
    .AW    (LAW)
  ) u_open_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  acc_closed_map #(
    .DEPTH (MAP_DEPTH),
    .AW    (MAW)
  ) u_closed_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .set_en   (map_set_en),
    .set_addr (map_set_addr),
    .rd_en    (map_rd_en),
    .rd_addr  (map_rd_addr),
    .rd_bit   (map_rd_bit),
    .busy     (map_busy)
  );

  assign in_tready = (state_r == ST_IDLE) && !map_busy;

  // Operation sequencer.
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    req_nxt        = req_r;
    pos_nxt        = pos_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_entry_nxt  = res_entry_r;
    res_closed_nxt = res_closed_r;
    ingrid_nxt     = ingrid_r;
    out_valid_nxt  = out_valid_r;
    out_user_nxt   = out_user_r;
    out_data_nxt   = out_data_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = ring_addr(head_r, pos_r);
    ram_wr_data    = req_r;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = ring_addr(head_r, pos_r - CW'(1));
    map_set_en     = 1'b0;
    map_set_addr   = req_idx;
    map_rd_en      = 1'b0;
    map_rd_addr    = req_idx;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          kind_nxt       = in_tuser;
          req_nxt        = in_entry;
          pos_nxt        = count_r;
          res_status_nxt = STAT_OK;
          res_entry_nxt  = '0;
          res_closed_nxt = 1'b0;
          unique case (in_tuser)
            KIND_PUSH: begin
              if (count_r == CW'(OPEN_DEPTH)) begin
                res_status_nxt = STAT_FULL;
                state_nxt      = ST_FINISH;
              end else begin
                state_nxt = ST_PUSH_RD;
              end
            end
            KIND_POP:   state_nxt = ST_POP_RD;
            KIND_CLOSE: state_nxt = ST_QUERY_RD;
            KIND_QUERY: state_nxt = ST_QUERY_RD;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      // Walk back from the tail, moving larger-f entries up by one.
      ST_PUSH_RD: begin
        if (pos_r == '0) begin
          ram_wr_en = 1'b1;
          count_nxt = count_r + CW'(1);
          state_nxt = ST_FINISH;
        end else begin
          ram_rd_en = 1'b1;
          state_nxt = ST_PUSH_CMP;
        end
      end
      ST_PUSH_CMP: begin
        ram_wr_en = 1'b1;
        if (ram_rd_data.f > req_r.f) begin
          ram_wr_data = ram_rd_data;
          pos_nxt     = pos_r - CW'(1);
          state_nxt   = ST_PUSH_RD;
        end else begin
          count_nxt = count_r + CW'(1);
          state_nxt = ST_FINISH;
        end
      end
      // Take the head entry and look up its vertex.
      ST_POP_RD: begin
        if (count_r == '0) begin
          res_status_nxt = STAT_EMPTY;
          state_nxt      = ST_FINISH;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = head_r;
          state_nxt   = ST_POP_MAP;
        end
      end
      ST_POP_MAP: begin
        res_entry_nxt = ram_rd_data;
        ingrid_nxt    = pop_in;
        map_rd_en     = 1'b1;
        map_rd_addr   = pop_idx;
        head_nxt      = ring_addr(head_r, CW'(1));
        count_nxt     = count_r - CW'(1);
        state_nxt     = ST_POP_CHK;
      end
      ST_POP_CHK: begin
        if (ingrid_r && map_rd_bit) begin
          res_entry_nxt = '0;
          state_nxt     = ST_POP_RD;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      // Close sets the bit; query reads it.
      ST_QUERY_RD: begin
        ingrid_nxt = req_in;
        if (kind_r == KIND_CLOSE) begin
          map_set_en = req_in;
          state_nxt  = ST_FINISH;
        end else begin
          map_rd_en = 1'b1;
          state_nxt = ST_QUERY_CHK;
        end
      end
      ST_QUERY_CHK: begin
        res_closed_nxt = ingrid_r && map_rd_bit;
        state_nxt      = ST_FINISH;
      end
      // Load the result once the output register is free.
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = res_status_r;
          out_data_nxt  = {6'd0, (count_r == '0), res_closed_r, res_entry_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    req_r        <= req_nxt;
    pos_r        <= pos_nxt;
    res_status_r <= res_status_nxt;
    res_entry_r  <= res_entry_nxt;
    res_closed_r <= res_closed_nxt;
    ingrid_r     <= ingrid_nxt;
    out_user_r   <= out_user_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

endmodule

@@ sv/acc_checker.sv @@
// ---------------------------------------------------------------------------
// acc_checker: port-level checks of the A* OPEN/CLOSED engine
// Watches the result channel and flags inconsistent result beats.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module acc_checker
  import acc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [1:0]  out_tuser,
  input logic [63:0] out_tdata
);

  // A stalled result beat stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat withdrawn while stalled");

  // A pop that finds nothing leaves OPEN empty and returns no entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_EMPTY) |-> out_tdata[57] && (out_tdata[55:0] == '0))
    else $error("empty pop with payload or nonempty list");

  // A dropped push means the list was full.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_FULL) |-> !out_tdata[57])
    else $error("full status with empty list");

  // No result beat straight after reset.
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat after reset");

  // The padding bits stay zero and the status code is a defined one.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[63:58] == '0) && (out_tuser != 2'd3))
    else $error("bad padding or status code");

endmodule

bind astar_open_closed_engine acc_checker u_acc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);
